/* rtl/core/rcws_pkg.sv */
`default_nettype none
package rcws_pkg;

	// register indexes on the configuration port
	typedef enum logic [3:0] {
		REG_LOCAL_RESOLUTION   = 4'd0,
		REG_LOCAL_HALF_WIDTH   = 4'd1,
		REG_LOCAL_HALF_HEIGHT  = 4'd2,
		REG_MAP_ORIGIN_X       = 4'd3,
		REG_MAP_ORIGIN_Y       = 4'd4,
		REG_MAP_INV_RESOLUTION = 4'd5,
		REG_MAP_WIDTH_CELLS    = 4'd6,
		REG_MAP_HEIGHT_CELLS   = 4'd7
	} reg_index_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	localparam int LOCAL_DIM_MAX = 512;

	localparam logic [30:0] RST_LOCAL_RESOLUTION   = 31'd1311;
	localparam logic [30:0] RST_LOCAL_HALF_WIDTH   = 31'd196608;
	localparam logic [30:0] RST_LOCAL_HALF_HEIGHT  = 31'd196608;
	localparam logic [31:0] RST_MAP_ORIGIN_X       = 32'd0;
	localparam logic [31:0] RST_MAP_ORIGIN_Y       = 32'd0;
	localparam logic [30:0] RST_MAP_INV_RESOLUTION = 31'd3276800;
	localparam logic [8:0]  RST_MAP_WIDTH_CELLS    = 9'd0;
	localparam logic [8:0]  RST_MAP_HEIGHT_CELLS   = 9'd0;

	// stored occupancy codes that count as lethal
	localparam logic signed [7:0] OCC_LETHAL = 8'sd100;
	localparam logic signed [7:0] OCC_UNKNOWN_LETHAL = -8'sd2;

	localparam logic signed [7:0] COST_LETHAL  = -8'sd128;
	localparam logic signed [7:0] COST_FREE    = 8'sd0;
	localparam logic signed [7:0] COST_OUTSIDE = -8'sd1;

endpackage
`default_nettype wire

/* rtl/core/rcws_ram.sv */
`default_nettype none
module rcws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/rotated_costmap_window_sampler_unit.sv */
`default_nettype none
// Rotated costmap window sampler. Items on the s_ stream either write one byte of the
// global occupancy grid (tuser = 0) or query one local window cell (tuser = 1).
// A query is centered, rotated by the given cos/sin of yaw, shifted by the pose,
// scaled into map cells and looked up; it returns -128 for lethal cells, 0 for
// other cells and -1 outside the map. Writes return nothing. One item is taken
// per clock while the output is not stalled. The nine-stage datapath, whose first
// register takes the item, is: offset multiply, rotation multiplies, rotation sums,
// translation, magnitude, the 46x31 scale multiply split into two partial products,
// their sum, the bounds check and the registered map read. Writes and reads hit the
// map memory at the same stage, so a query always sees every write accepted before
// it. The map memory holds MAP_DIM_MAX*MAP_DIM_MAX cells and needs no clearing
// after reset.
module rotated_costmap_window_sampler_unit #(
	parameter int MAP_DIM_MAX = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [3:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	// request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// map_address[15:0], map_value[23:16], local_row[32:24], local_col[41:33],
	// pose_x[73:42], pose_y[105:74], cos_yaw[121:106], sin_yaw[137:122], zero fill
	input  wire logic [143:0] s_tdata,
	// req_type[0]
	input  wire logic         s_tuser,
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// cell_cost[7:0], out_row[16:8], out_col[25:17], zero fill
	output logic [31:0]       m_tdata
);

	localparam int MAP_CELLS = MAP_DIM_MAX * MAP_DIM_MAX;
	localparam int AW = $clog2(MAP_CELLS);
	localparam int XW = $clog2(MAP_DIM_MAX);
	localparam int DW = $clog2(MAP_DIM_MAX + 1);
	localparam int IW = XW + DW;

	typedef struct packed {
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  value;
		logic [8:0]  row;
		logic [8:0]  col;
	} meta_t;

	// ---------------------------------------------------------------- config
	logic [30:0] local_res_q;
	logic [30:0] half_w_q;
	logic [30:0] half_h_q;
	logic [31:0] org_x_q;
	logic [31:0] org_y_q;
	logic [30:0] inv_res_q;
	logic [8:0]  map_w_q;
	logic [8:0]  map_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_res_q <= rcws_pkg::RST_LOCAL_RESOLUTION;
			half_w_q    <= rcws_pkg::RST_LOCAL_HALF_WIDTH;
			half_h_q    <= rcws_pkg::RST_LOCAL_HALF_HEIGHT;
			org_x_q     <= rcws_pkg::RST_MAP_ORIGIN_X;
			org_y_q     <= rcws_pkg::RST_MAP_ORIGIN_Y;
			inv_res_q   <= rcws_pkg::RST_MAP_INV_RESOLUTION;
			map_w_q     <= rcws_pkg::RST_MAP_WIDTH_CELLS;
			map_h_q     <= rcws_pkg::RST_MAP_HEIGHT_CELLS;
		end else if (cfg_valid) begin
			unique case (rcws_pkg::reg_index_t'(cfg_index))
				rcws_pkg::REG_LOCAL_RESOLUTION:   local_res_q <= cfg_data[30:0];
				rcws_pkg::REG_LOCAL_HALF_WIDTH:   half_w_q    <= cfg_data[30:0];
				rcws_pkg::REG_LOCAL_HALF_HEIGHT:  half_h_q    <= cfg_data[30:0];
				rcws_pkg::REG_MAP_ORIGIN_X:       org_x_q     <= cfg_data;
				rcws_pkg::REG_MAP_ORIGIN_Y:       org_y_q     <= cfg_data;
				rcws_pkg::REG_MAP_INV_RESOLUTION: inv_res_q   <= cfg_data[30:0];
				rcws_pkg::REG_MAP_WIDTH_CELLS:    map_w_q     <= cfg_data[8:0];
				rcws_pkg::REG_MAP_HEIGHT_CELLS:   map_h_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic [DW-1:0] w_cap;
	logic [DW-1:0] h_cap;

	assign w_cap = (32'(map_w_q) > MAP_DIM_MAX) ? DW'(MAP_DIM_MAX) : DW'(map_w_q);
	assign h_cap = (32'(map_h_q) > MAP_DIM_MAX) ? DW'(MAP_DIM_MAX) : DW'(map_h_q);

	// ---------------------------------------------------------------- input unpack
	meta_t              meta_in;
	logic signed [31:0] pose_x_in;
	logic signed [31:0] pose_y_in;
	logic signed [15:0] cos_in;
	logic signed [15:0] sin_in;
	logic               keep_in;

	assign meta_in.wr    = (s_tuser == rcws_pkg::REQ_WRITE);
	assign meta_in.addr  = s_tdata[15:0];
	assign meta_in.value = s_tdata[23:16];
	assign meta_in.row   = s_tdata[32:24];
	assign meta_in.col   = s_tdata[41:33];
	assign pose_x_in     = s_tdata[73:42];
	assign pose_y_in     = s_tdata[105:74];
	assign cos_in        = s_tdata[121:106];
	assign sin_in        = s_tdata[137:122];

	// queries outside the local window produce nothing and are dropped
	assign keep_in = meta_in.wr ||
		((32'(meta_in.row) < rcws_pkg::LOCAL_DIM_MAX) &&
		 (32'(meta_in.col) < rcws_pkg::LOCAL_DIM_MAX));

	// ---------------------------------------------------------------- flow control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

	// each stage moves when it is empty or the next one moves, so bubbles collapse
	assign en9 = !v_s9 || m_tready;
	assign en8 = !v_s8 || en9;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign s_tready = en1;

	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7, meta_s8, meta_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid && keep_in;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			// writes retire into the memory and leave no result
			if (en9) v_s9 <= v_s8 && !meta_s8.wr;
		end
	end

	// ---------------------------------------------------------------- datapath
	logic signed [40:0] bx_s1, by_s1;
	logic signed [31:0] pose_x_s1, pose_y_s1, pose_x_s2, pose_y_s2, pose_x_s3, pose_y_s3;
	logic signed [15:0] cos_s1, sin_s1;
	logic signed [56:0] p_xc_s2, p_ys_s2, p_xs_s2, p_yc_s2;
	logic signed [57:0] sx_s3, sy_s3;
	logic signed [45:0] dx_s4, dy_s4;
	logic [45:0]        ax_s5, ay_s5;
	logic               nx_s5, ny_s5, nx_s6, ny_s6, nx_s7, ny_s7;
	logic [62:0]        lox_s6, loy_s6;
	logic [44:0]        hix_s6, hiy_s6;
	logic [45:0]        qx_s7, qy_s7;
	logic               in_s8, in_s9;
	logic [XW-1:0]      mx_s8, my_s8;

	logic [39:0] col_res, row_res;
	logic        in_x, in_y;

	assign col_res = 40'(meta_in.col) * 40'(local_res_q);
	assign row_res = 40'(meta_in.row) * 40'(local_res_q);

	// a negative offset is inside only when it truncates to cell zero
	assign in_x = (!nx_s7 || qx_s7 == '0) && (qx_s7 < 46'(w_cap));
	assign in_y = (!ny_s7 || qy_s7 == '0) && (qy_s7 < 46'(h_cap));

	always_ff @(posedge clk) begin
		if (en1) begin
			meta_s1   <= meta_in;
			bx_s1     <= $signed({1'b0, col_res}) - $signed({10'd0, half_w_q});
			by_s1     <= $signed({1'b0, row_res}) - $signed({10'd0, half_h_q});
			pose_x_s1 <= pose_x_in;
			pose_y_s1 <= pose_y_in;
			cos_s1    <= cos_in;
			sin_s1    <= sin_in;
		end
		if (en2) begin
			meta_s2   <= meta_s1;
			p_xc_s2   <= 57'(bx_s1) * 57'(cos_s1);
			p_ys_s2   <= 57'(by_s1) * 57'(sin_s1);
			p_xs_s2   <= 57'(bx_s1) * 57'(sin_s1);
			p_yc_s2   <= 57'(by_s1) * 57'(cos_s1);
			pose_x_s2 <= pose_x_s1;
			pose_y_s2 <= pose_y_s1;
		end
		if (en3) begin
			meta_s3   <= meta_s2;
			sx_s3     <= 58'(p_xc_s2) - 58'(p_ys_s2);
			sy_s3     <= 58'(p_xs_s2) + 58'(p_yc_s2);
			pose_x_s3 <= pose_x_s2;
			pose_y_s3 <= pose_y_s2;
		end
		if (en4) begin
			meta_s4 <= meta_s3;
			// arithmetic shift floors the Q1.14 product back to Q16.16
			dx_s4   <= 46'(pose_x_s3) - 46'($signed(org_x_q)) + 46'(sx_s3 >>> 14);
			dy_s4   <= 46'(pose_y_s3) - 46'($signed(org_y_q)) + 46'(sy_s3 >>> 14);
		end
		if (en5) begin
			meta_s5 <= meta_s4;
			nx_s5   <= dx_s4[45];
			ny_s5   <= dy_s4[45];
			ax_s5   <= dx_s4[45] ? 46'(-dx_s4) : 46'(dx_s4);
			ay_s5   <= dy_s4[45] ? 46'(-dy_s4) : 46'(dy_s4);
		end
		if (en6) begin
			meta_s6 <= meta_s5;
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			lox_s6  <= 63'(ax_s5[31:0]) * 63'(inv_res_q);
			hix_s6  <= 45'(ax_s5[45:32]) * 45'(inv_res_q);
			loy_s6  <= 63'(ay_s5[31:0]) * 63'(inv_res_q);
			hiy_s6  <= 45'(ay_s5[45:32]) * 45'(inv_res_q);
		end
		if (en7) begin
			meta_s7 <= meta_s6;
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			qx_s7   <= 46'(hix_s6) + 46'(lox_s6[62:32]);
			qy_s7   <= 46'(hiy_s6) + 46'(loy_s6[62:32]);
		end
		if (en8) begin
			meta_s8 <= meta_s7;
			in_s8   <= in_x && in_y;
			mx_s8   <= qx_s7[XW-1:0];
			my_s8   <= qy_s7[XW-1:0];
		end
		if (en9) begin
			meta_s9 <= meta_s8;
			in_s9   <= in_s8;
		end
	end

	// ---------------------------------------------------------------- map memory
	logic [IW-1:0] idx_full;
	logic [31:0]   waddr_full;
	logic [AW-1:0] ram_raddr;
	logic [AW-1:0] ram_waddr;
	logic          ram_we;
	logic          ram_re;
	logic [7:0]    ram_rdata;

	assign idx_full   = IW'(my_s8) * IW'(w_cap) + IW'(mx_s8);
	assign ram_raddr  = idx_full[AW-1:0];
	assign waddr_full = 32'(meta_s8.addr);
	assign ram_waddr  = waddr_full[AW-1:0];
	// both kinds of item touch the memory as they leave stage 8, in item order
	assign ram_we = v_s8 && en9 && meta_s8.wr && (waddr_full < 32'(MAP_CELLS));
	assign ram_re = v_s8 && en9 && !meta_s8.wr;

	rcws_ram #(
		.WIDTH (8),
		.DEPTH (MAP_CELLS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (meta_s8.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- result
	logic signed [7:0] cost;
	logic signed [7:0] occ;

	assign occ = $signed(ram_rdata);

	always_comb begin
		if (!in_s9) begin
			cost = rcws_pkg::COST_OUTSIDE;
		end else if (occ == rcws_pkg::OCC_LETHAL || occ == rcws_pkg::OCC_UNKNOWN_LETHAL) begin
			cost = rcws_pkg::COST_LETHAL;
		end else begin
			cost = rcws_pkg::COST_FREE;
		end
	end

	assign m_tvalid = v_s9;
	assign m_tdata  = {6'd0, meta_s9.col, meta_s9.row, cost};

endmodule
`default_nettype wire
